[src/lpstep_pkg.sv]
// ----------------------------------------------------------------------------
// lpstep_pkg
// Shared types, widths and helpers of the line pixel stepper: segment and
// pixel items, the classified job that goes from front to back, queue status.
// ----------------------------------------------------------------------------
package lpstep_pkg;

    localparam int COORD_BITS  = 6;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int DEC_BITS    = 9;
    localparam int WIDE_BITS   = DEC_BITS + 2;
    localparam int QUEUE_DEPTH = 2;

    // one input item: a segment
    typedef struct packed {
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } seg_t;

    // one result item: a pixel
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last_pixel;
    } pix_t;

    // segment prepared for stepping
    typedef struct packed {
        logic [COORD_BITS-1:0]        cur_x;
        logic [COORD_BITS-1:0]        cur_y;
        logic [COORD_BITS-1:0]        limit_x;
        logic [COORD_BITS-1:0]        limit_y;
        logic signed [DIFF_BITS-1:0]  run_dx;
        logic signed [DIFF_BITS-1:0]  run_dy;
        logic signed [DEC_BITS-1:0]   decision;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic signed [WIDE_BITS-1:0] DEC_MAX = WIDE_BITS'(2**(DEC_BITS-1) - 1);
    localparam logic signed [WIDE_BITS-1:0] DEC_MIN = -WIDE_BITS'(2**(DEC_BITS-1));

    // clamp a wide decision sum into the decision register range
    function automatic logic signed [DEC_BITS-1:0] sat_dec(input logic signed [WIDE_BITS-1:0] v);
        logic signed [DEC_BITS-1:0] r;
        if (v > DEC_MAX) begin
            r = DEC_MAX[DEC_BITS-1:0];
        end else if (v < DEC_MIN) begin
            r = DEC_MIN[DEC_BITS-1:0];
        end else begin
            r = v[DEC_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[src/lpstep_front.sv]
// ----------------------------------------------------------------------------
// lpstep_front
// Accepts segment items, drops those that cannot yield a pixel and turns the
// rest into jobs with run lengths and the starting decision term.
// ----------------------------------------------------------------------------
module lpstep_front (
    input  logic                  seg_valid,
    output logic                  seg_stall,
    input  lpstep_pkg::seg_t      seg,
    input  lpstep_pkg::q_status_t q_status,
    output logic                  push,
    output lpstep_pkg::job_t      job
);
    import lpstep_pkg::*;

    logic                        drop;
    logic signed [WIDE_BITS-1:0] dx_w;
    logic signed [WIDE_BITS-1:0] dy_w;

    // hold the source while the queue has no room
    assign seg_stall = q_status.full;

    // drop empty x spans and descending segments
    assign drop = (seg.end_x <= seg.start_x) || (seg.start_y > seg.end_y);
    assign push = seg_valid && !q_status.full && !drop;

    // form run lengths and the starting decision term
    assign dx_w = WIDE_BITS'(signed'({1'b0, seg.end_x})) - WIDE_BITS'(signed'({1'b0, seg.start_x}));
    assign dy_w = WIDE_BITS'(signed'({1'b0, seg.end_y})) - WIDE_BITS'(signed'({1'b0, seg.start_y}));

    assign job.cur_x    = seg.start_x;
    assign job.cur_y    = seg.start_y;
    assign job.limit_x  = seg.end_x;
    assign job.limit_y  = seg.end_y;
    assign job.run_dx   = dx_w[DIFF_BITS-1:0];
    assign job.run_dy   = dy_w[DIFF_BITS-1:0];
    assign job.decision = sat_dec((dy_w <<< 1) - dx_w);

endmodule

[src/lpstep_queue.sv]
// ----------------------------------------------------------------------------
// lpstep_queue
// Short job queue between front and back so either side can stall alone.
// ----------------------------------------------------------------------------
module lpstep_queue #(
    parameter int DEPTH = lpstep_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lpstep_pkg::job_t      push_job,
    input  logic                  pop,
    output lpstep_pkg::job_t      head_job,
    output lpstep_pkg::q_status_t q_status
);
    import lpstep_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    job_t                entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign head_job       = entry_reg[rd_ptr_reg];

    // advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[src/lpstep_back.sv]
// ----------------------------------------------------------------------------
// lpstep_back
// Steps one job at a time, one pixel a cycle while the output is not stalled, into a registered pixel output.
// The pixel after the current one is looked at ahead to set the last mark.
// ----------------------------------------------------------------------------
module lpstep_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpstep_pkg::q_status_t q_status,
    input  lpstep_pkg::job_t      head_job,
    output logic                  pop,
    output logic                  pix_valid,
    input  logic                  pix_stall,
    output lpstep_pkg::pix_t      pix
);
    import lpstep_pkg::*;

    logic                        busy_reg, busy_next;
    logic [COORD_BITS-1:0]       cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]       cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]       limit_x_reg, limit_x_next;
    logic [COORD_BITS-1:0]       limit_y_reg, limit_y_next;
    logic signed [DIFF_BITS-1:0] run_dx_reg, run_dx_next;
    logic signed [DIFF_BITS-1:0] run_dy_reg, run_dy_next;
    logic signed [DEC_BITS-1:0]  decision_reg, decision_next;
    logic                        pix_valid_reg, pix_valid_next;
    pix_t                        pix_reg, pix_next;

    logic                        advance;
    logic                        up;
    logic                        up_ahead;
    logic                        x_done;
    logic                        y_over;
    logic                        last;
    logic [COORD_BITS-1:0]       nx;
    logic [COORD_BITS:0]         ny;
    logic [COORD_BITS+1:0]       ny_ahead;
    logic signed [WIDE_BITS-1:0] dec_w;
    logic signed [WIDE_BITS-1:0] dx2_w;
    logic signed [WIDE_BITS-1:0] dy2_w;
    logic signed [DEC_BITS-1:0]  dec_new;

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // take the next job once the current one is finished
    assign pop     = !busy_reg && !q_status.empty;
    assign advance = busy_reg && (!pix_valid_reg || !pix_stall);

    // one Bresenham step and a look at the step after it
    assign up     = !decision_reg[DEC_BITS-1];
    assign x_done = (cur_x_reg >= limit_x_reg);
    assign ny     = {1'b0, cur_y_reg} + {{COORD_BITS{1'b0}}, up};
    assign y_over = (ny > {1'b0, limit_y_reg});
    assign nx     = cur_x_reg + 1'b1;

    assign dec_w   = WIDE_BITS'(decision_reg);
    assign dx2_w   = WIDE_BITS'(run_dx_reg) <<< 1;
    assign dy2_w   = WIDE_BITS'(run_dy_reg) <<< 1;
    assign dec_new = sat_dec(up ? (dec_w + dy2_w - dx2_w) : (dec_w + dy2_w));

    assign up_ahead = !dec_new[DEC_BITS-1];
    assign ny_ahead = {1'b0, ny} + {{(COORD_BITS+1){1'b0}}, up_ahead};
    assign last     = (nx >= limit_x_reg) || (ny_ahead > {2'b00, limit_y_reg});

    always_comb
    begin
        busy_next      = busy_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        limit_x_next   = limit_x_reg;
        limit_y_next   = limit_y_reg;
        run_dx_next    = run_dx_reg;
        run_dy_next    = run_dy_reg;
        decision_next  = decision_reg;
        pix_valid_next = pix_valid_reg;
        pix_next       = pix_reg;

        // drop the shown item once taken
        if (pix_valid_reg && !pix_stall)
        begin
            pix_valid_next = 1'b0;
        end

        if (pop)
        begin
            // load a job
            busy_next     = 1'b1;
            cur_x_next    = head_job.cur_x;
            cur_y_next    = head_job.cur_y;
            limit_x_next  = head_job.limit_x;
            limit_y_next  = head_job.limit_y;
            run_dx_next   = head_job.run_dx;
            run_dy_next   = head_job.run_dy;
            decision_next = head_job.decision;
        end
        else if (advance)
        begin
            if (x_done || y_over)
            begin
                // stop without a pixel
                busy_next = 1'b0;
            end
            else
            begin
                // emit a pixel and move on
                pix_valid_next      = 1'b1;
                pix_next.pixel_x    = nx;
                pix_next.pixel_y    = ny[COORD_BITS-1:0];
                pix_next.last_pixel = last;
                cur_x_next          = nx;
                cur_y_next          = ny[COORD_BITS-1:0];
                decision_next       = dec_new;
                if (last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // hold step state and payload
    always_ff @(posedge clk)
    begin
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        limit_x_reg  <= limit_x_next;
        limit_y_reg  <= limit_y_next;
        run_dx_reg   <= run_dx_next;
        run_dy_reg   <= run_dy_next;
        decision_reg <= decision_next;
        pix_reg      <= pix_next;
    end

endmodule

[src/line_pixel_stepper.sv]
// ----------------------------------------------------------------------------
// line_pixel_stepper
// First-octant Bresenham line stepper: one segment in, its pixels out.
// ----------------------------------------------------------------------------
// Each segment item yields the pixels from start_x+1 up to end_x, one pixel
// item per cycle while the output is not stalled, with last_pixel set on the
// final one; the segment stops early once y would pass end_y. In the stepping
// unit a segment takes a load step and then the pixel loop; segments that
// give no pixel by their end points are dropped on entry. A short job queue
// lets new segments be taken while the previous one is still being stepped.
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
    parameter int QUEUE_DEPTH = lpstep_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             seg_valid,
    output logic             seg_stall,
    input  lpstep_pkg::seg_t seg,
    output logic             pix_valid,
    input  logic             pix_stall,
    output lpstep_pkg::pix_t pix
);
    import lpstep_pkg::*;

    q_status_t q_status;
    job_t      push_job;
    job_t      head_job;
    logic      push;
    logic      pop;

    lpstep_front u_front (
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .q_status  (q_status),
        .push      (push),
        .job       (push_job)
    );

    lpstep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    lpstep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_job  (head_job),
        .pop       (pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule
